FILE: src/sipq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
// No dependencies.
package sipq_pkg;

    localparam int IdW     = 16;
    localparam int PrioW   = 16;
    localparam int StatusW = 2;
    localparam int FillW   = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
    localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

    typedef logic        [IdW-1:0]   t_id;
    typedef logic signed [PrioW-1:0] t_prio;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

FILE: src/sipq_cell.sv
// One slot of the sorted table: holds an identifier and a priority.
// Depends on sipq_pkg.
module sipq_cell
    import sipq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_id       i_new_id,
    input  t_prio     i_new_prio,
    input  logic      i_left_take,
    input  t_id       i_left_id,
    input  t_prio     i_left_prio,
    input  t_id       i_right_id,
    input  t_prio     i_right_prio,
    output logic      o_take,
    output t_id       o_id,
    output t_prio     o_prio
);

    t_id   r_id;
    t_prio r_prio;

    // take: this slot is free or holds a strictly lower priority
    assign o_take = !i_occupied || (r_prio < i_new_prio);
    assign o_id   = r_id;
    assign o_prio = r_prio;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && o_take) begin
            if (i_left_take) begin
                r_id   <= i_left_id;
                r_prio <= i_left_prio;
            end else begin
                r_id   <= i_new_id;
                r_prio <= i_new_prio;
            end
        end else if (i_ctl.rem) begin
            r_id   <= i_right_id;
            r_prio <= i_right_prio;
        end
    end

endmodule

FILE: src/sorted_insert_priority_queue_top.sv
// Top level of the sorted-insert priority queue: a chain of sipq_cell slots,
// the fill count and the result register.
// Depends on sipq_pkg and sipq_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: i_kind
//   selects insert (0) or remove head (1); i_item_id and i_prio are the entry
//   to insert. Output channel (o_out_valid / i_out_ready) returns one result
//   per request: o_status, o_head_id, o_head_prio, o_fill, o_is_empty.
//   Every slot compares its priority with the new one in parallel and shifts
//   toward its neighbor in the same cycle, so a request's result shows in
//   the result register in the cycle after it is accepted. Throughput is
//   one request per cycle while each result is taken; the result register
//   is the only stage. o_in_ready is high while the result register is empty
//   or being taken, so a stalled receiver holds the result and stops intake
//   after one request. Reset empties the queue and the result register; slot
//   contents are not cleared and are never read before being written.
module sorted_insert_priority_queue_top
    import sipq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [IdW-1:0]     i_item_id,
    input  logic signed [PrioW-1:0] i_prio,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [StatusW-1:0] o_status,
    output logic [IdW-1:0]     o_head_id,
    output logic signed [PrioW-1:0] o_head_prio,
    output logic [FillW-1:0]   o_fill,
    output logic               o_is_empty
);

    localparam int CntW = $clog2(DEPTH + 1);

    logic [CntW-1:0]    r_count, n_count;
    logic               r_valid;
    logic [StatusW-1:0] r_status, n_status;
    t_id                r_head_id, n_head_id;
    t_prio              r_head_prio, n_head_prio;
    logic [FillW-1:0]   r_fill;
    logic               r_empty;

    logic        w_fire, w_full, w_none;
    logic [31:0] w_fill_wide;
    t_cell_ctl   w_ctl;
    logic        w_take [DEPTH];
    t_id         w_id   [DEPTH];
    t_prio       w_prio [DEPTH];

    assign o_in_ready = !r_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CntW'(DEPTH));
    assign w_none     = (r_count == '0);

    assign w_ctl.ins = w_fire && (i_kind == KIND_INSERT) && !w_full;
    assign w_ctl.rem = w_fire && (i_kind == KIND_REMOVE) && !w_none;

    always_comb begin
        n_count     = r_count;
        n_status    = STATUS_DONE;
        n_head_id   = '0;
        n_head_prio = '0;
        if (i_kind == KIND_INSERT) begin
            if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_none) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_count     = r_count - 1'b1;
                n_head_id   = w_id[0];
                n_head_prio = w_prio[0];
            end
        end
    end

    assign w_fill_wide = 32'(n_count);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  w_left_take;
        t_id   w_left_id, w_right_id;
        t_prio w_left_prio, w_right_prio;

        if (i == 0) begin : g_head
            assign w_left_take = 1'b0;
            assign w_left_id   = i_item_id;
            assign w_left_prio = i_prio;
        end else begin : g_body
            assign w_left_take = w_take[i-1];
            assign w_left_id   = w_id[i-1];
            assign w_left_prio = w_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_right_id   = w_id[i];
            assign w_right_prio = w_prio[i];
        end else begin : g_mid
            assign w_right_id   = w_id[i+1];
            assign w_right_prio = w_prio[i+1];
        end

        sipq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (r_count > CntW'(i)),
            .i_new_id     (i_item_id),
            .i_new_prio   (i_prio),
            .i_left_take  (w_left_take),
            .i_left_id    (w_left_id),
            .i_left_prio  (w_left_prio),
            .i_right_id   (w_right_id),
            .i_right_prio (w_right_prio),
            .o_take       (w_take[i]),
            .o_id         (w_id[i]),
            .o_prio       (w_prio[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= n_status;
            r_head_id   <= n_head_id;
            r_head_prio <= n_head_prio;
            r_fill      <= w_fill_wide[FillW-1:0];
            r_empty     <= (n_count == '0);
        end
    end

    assign o_out_valid = r_valid;
    assign o_status    = r_status;
    assign o_head_id   = r_head_id;
    assign o_head_prio = r_head_prio;
    assign o_fill      = r_fill;
    assign o_is_empty  = r_empty;

endmodule
